// ===== hdl/btbf_pkg.sv =====
// Shared types, codes and constants of the boundary-tag best-fit allocator.
// Used by btbf_ctrl, btbf_datapath and boundary_tag_best_fit_allocator_top.
package btbf_pkg;

  localparam int ARENA_BYTES_DEF = 16384;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_INIT   = 4'd1;
  localparam logic [OP_W-1:0] OP_START  = 4'd2;
  localparam logic [OP_W-1:0] OP_AWALK  = 4'd3;
  localparam logic [OP_W-1:0] OP_APREP  = 4'd4;
  localparam logic [OP_W-1:0] OP_RPREP  = 4'd5;
  localparam logic [OP_W-1:0] OP_WH     = 4'd6;
  localparam logic [OP_W-1:0] OP_WT     = 4'd7;
  localparam logic [OP_W-1:0] OP_FWALK  = 4'd8;
  localparam logic [OP_W-1:0] OP_SCAN0  = 4'd9;
  localparam logic [OP_W-1:0] OP_SCAN   = 4'd10;
  localparam logic [OP_W-1:0] OP_RDNEXT = 4'd11;
  localparam logic [OP_W-1:0] OP_MNEXT  = 4'd12;
  localparam logic [OP_W-1:0] OP_RDPREV = 4'd13;
  localparam logic [OP_W-1:0] OP_MPREV  = 4'd14;
  localparam logic [OP_W-1:0] OP_RESULT = 4'd15;

  typedef struct packed {
    logic        kind;
    logic [13:0] request_bytes;
    logic [13:0] block_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] granted_offset;
    logic [13:0] granted_bytes;
    logic        arena_emptied;
  } out_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      status;
    logic            emptied;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic req_zero;
    logic live;
    logic mark;
    logic exact;
    logic found;
    logic heq;
    logic hgt;
    logic split;
    logic merge_ok;
    logic prev_fits;
    logic init_last;
  } stat_t;

endpackage

// ===== hdl/btbf_datapath.sv =====
// Datapath of the allocator: arena memory, walk pointers, tag arithmetic and
// result register. Depends on btbf_pkg; driven by btbf_ctrl through cmd_t.
module btbf_datapath #(
  parameter int ARENA_BYTES = btbf_pkg::ARENA_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  btbf_pkg::in_t   in_item,
  input  btbf_pkg::cmd_t  cmd,
  output btbf_pkg::stat_t stat,
  output btbf_pkg::out_t  out_item
);
  import btbf_pkg::*;

  localparam int N  = ARENA_BYTES / 4;
  localparam int SW = $clog2(ARENA_BYTES);
  localparam int AW = SW - 2;
  localparam int CW = ((SW > 14) ? SW : 14) + 1;
  localparam logic [31:0] FULL_TAG = 32'(ARENA_BYTES - 16);

  logic [31:0] mem [N];
  logic [31:0] rdata_r;
  logic [AW-1:0] raddr, waddr;
  logic [31:0] wdata;
  logic we;

  logic [AW-1:0] h_r, h_nxt, w_r, w_nxt, best_r, best_nxt, wa_r, wa_nxt;
  logic [SW-1:0] bs_r, bs_nxt, ws_r, ws_nxt;
  logic [CW-1:0] bd_r, bd_nxt;
  logic          wm_r, wm_nxt, found_r, found_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          kind_r;
  logic [13:0]   req_r, off_r, gro_r, grb_r;
  out_t          res_r;

  logic [SW-1:0] sz;
  logic [CW-1:0] szc, reqc, left, hc, offc;
  logic [AW-1:0] hn, wn;
  logic live, mark, better, prev_fits;

  always_comb begin
    sz        = {rdata_r[SW-1:1], 1'b0};
    szc       = CW'(sz);
    reqc      = CW'(req_r);
    left      = (reqc + CW'(3)) & ~CW'(3);
    hc        = CW'({h_r, 2'b00});
    offc      = CW'(off_r);
    live      = (sz != '0);
    mark      = rdata_r[0];
    hn        = AW'(h_r + AW'(2) + sz[SW-1:2]);
    wn        = AW'(w_r + AW'(2) + sz[SW-1:2]);
    better    = live && !mark && (szc > reqc) && ((szc - reqc) < bd_r);
    prev_fits = ({1'b0, sz[SW-1:2]} + (AW+1)'(2)) <= {1'b0, h_r};

    stat.kind      = kind_r;
    stat.req_zero  = (req_r == '0);
    stat.live      = live;
    stat.mark      = mark;
    stat.exact     = live && !mark && (szc == reqc);
    stat.found     = found_r;
    stat.heq       = (hc == offc);
    stat.hgt       = (hc > offc);
    stat.split     = CW'(bs_r) >= (reqc + CW'(16));
    stat.merge_ok  = live && !mark;
    stat.prev_fits = prev_fits;
    stat.init_last = (idx_r == 2'd3);
  end

  always_comb begin
    h_nxt = h_r; w_nxt = w_r; best_nxt = best_r; bs_nxt = bs_r; bd_nxt = bd_r;
    found_nxt = found_r; wa_nxt = wa_r; ws_nxt = ws_r; wm_nxt = wm_r;
    idx_nxt = idx_r;
    raddr = h_r; waddr = wa_r; wdata = 32'({ws_r[SW-1:1], wm_r}); we = 1'b0;
    unique case (cmd.op)
      OP_INIT: begin
        we = 1'b1;
        idx_nxt = idx_r + 2'd1;
        case (idx_r)
          2'd0: begin waddr = '0; wdata = '0; end
          2'd1: begin waddr = AW'(1); wdata = FULL_TAG; end
          2'd2: begin waddr = AW'(N - 2); wdata = FULL_TAG; end
          default: begin waddr = AW'(N - 1); wdata = '0; end
        endcase
      end
      OP_START: begin
        h_nxt = AW'(1); found_nxt = 1'b0; bd_nxt = '1; raddr = AW'(1);
      end
      OP_AWALK: begin
        if (stat.exact) begin
          best_nxt = h_r; bs_nxt = sz; found_nxt = 1'b1;
        end else begin
          if (better) begin
            best_nxt = h_r; bs_nxt = sz; bd_nxt = szc - reqc; found_nxt = 1'b1;
          end
          h_nxt = hn;
          raddr = hn;
        end
      end
      OP_APREP: begin
        wa_nxt = best_r; wm_nxt = 1'b1;
        ws_nxt = stat.split ? left[SW-1:0] : bs_r;
      end
      OP_RPREP: begin
        wa_nxt = AW'(best_r + AW'(2) + ws_r[SW-1:2]); wm_nxt = 1'b0;
        ws_nxt = SW'(bs_r - ws_r - SW'(8));
      end
      OP_WH: we = 1'b1;
      OP_WT: begin
        we = 1'b1;
        waddr = AW'(wa_r + AW'(1) + ws_r[SW-1:2]);
      end
      OP_FWALK: begin
        if (stat.heq) begin
          wa_nxt = h_r; ws_nxt = sz; wm_nxt = 1'b0;
        end else if (live && !stat.hgt) begin
          h_nxt = hn;
          raddr = hn;
        end
      end
      OP_SCAN0: begin
        w_nxt = AW'(1); raddr = AW'(1);
      end
      OP_SCAN: begin
        w_nxt = wn; raddr = wn;
      end
      OP_RDNEXT: raddr = AW'(h_r + AW'(2) + ws_r[SW-1:2]);
      OP_MNEXT: begin
        if (stat.merge_ok) ws_nxt = SW'(ws_r + sz + SW'(8));
      end
      OP_RDPREV: raddr = AW'(h_r - AW'(1));
      OP_MPREV: begin
        if (stat.merge_ok && prev_fits) begin
          wa_nxt = AW'(h_r - AW'(2) - sz[SW-1:2]);
          ws_nxt = SW'(ws_r + sz + SW'(8));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt; w_r <= w_nxt; best_r <= best_nxt; bs_r <= bs_nxt; bd_r <= bd_nxt;
    wa_r <= wa_nxt; ws_r <= ws_nxt; wm_r <= wm_nxt;
    if (cmd.op == OP_START) begin
      kind_r <= in_item.kind;
      req_r  <= in_item.request_bytes;
      off_r  <= in_item.block_offset;
    end
    if (cmd.op == OP_APREP) begin
      gro_r <= 14'({best_r, 2'b00});
      grb_r <= 14'(ws_nxt);
    end
    if (cmd.op == OP_RESULT) begin
      res_r.status         <= cmd.status;
      res_r.arena_emptied  <= cmd.emptied;
      res_r.granted_offset <= (cmd.status == ST_OK && kind_r == KIND_ALLOC) ? gro_r : '0;
      res_r.granted_bytes  <= (cmd.status == ST_OK && kind_r == KIND_ALLOC) ? grb_r : '0;
    end
  end

  assign out_item = res_r;

endmodule

// ===== hdl/btbf_ctrl.sv =====
// Sequencer of the allocator: steps the datapath through walks and tag writes.
// Depends on btbf_pkg; talks to btbf_datapath through cmd_t and stat_t.
module btbf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  btbf_pkg::stat_t stat,
  output btbf_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            out_valid
);
  import btbf_pkg::*;

  localparam logic [4:0] S_INIT  = 5'd0,  S_IDLE  = 5'd1,  S_DISP  = 5'd2,
                         S_AWALK = 5'd3,  S_AEND  = 5'd4,  S_AWH   = 5'd5,
                         S_AWT   = 5'd6,  S_RPREP = 5'd7,  S_RWH   = 5'd8,
                         S_RWT   = 5'd9,  S_FWALK = 5'd10, S_FWH   = 5'd11,
                         S_FWT   = 5'd12, S_SCAN0 = 5'd13, S_SCAN  = 5'd14,
                         S_EMPTY = 5'd15, S_RDNX  = 5'd16, S_MNX   = 5'd17,
                         S_NWH   = 5'd18, S_NWT   = 5'd19, S_RDPV  = 5'd20,
                         S_MPV   = 5'd21, S_PWH   = 5'd22, S_PWT   = 5'd23,
                         S_RES   = 5'd24, S_OUT   = 5'd25;

  logic [4:0] state_r, state_nxt;
  logic [1:0] st_r, st_nxt;
  logic       emp_r, emp_nxt;

  always_comb begin
    state_nxt = state_r; st_nxt = st_r; emp_nxt = emp_r;
    cmd.op = OP_NONE; cmd.status = st_r; cmd.emptied = emp_r;
    unique case (state_r)
      S_INIT: begin
        cmd.op = OP_INIT;
        if (stat.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_START; state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        st_nxt = ST_OK; emp_nxt = 1'b0;
        if (stat.kind == KIND_FREE) state_nxt = S_FWALK;
        else if (stat.req_zero) begin
          st_nxt = ST_NOFIT; state_nxt = S_RES;
        end else state_nxt = S_AWALK;
      end
      S_AWALK: begin
        cmd.op = OP_AWALK;
        if (!stat.live || stat.exact) state_nxt = S_AEND;
      end
      S_AEND: begin
        if (!stat.found) begin
          st_nxt = ST_NOFIT; state_nxt = S_RES;
        end else begin
          cmd.op = OP_APREP; state_nxt = S_AWH;
        end
      end
      S_AWH: begin cmd.op = OP_WH; state_nxt = S_AWT; end
      S_AWT: begin
        cmd.op = OP_WT;
        state_nxt = stat.split ? S_RPREP : S_RES;
      end
      S_RPREP: begin cmd.op = OP_RPREP; state_nxt = S_RWH; end
      S_RWH: begin cmd.op = OP_WH; state_nxt = S_RWT; end
      S_RWT: begin cmd.op = OP_WT; state_nxt = S_RES; end
      S_FWALK: begin
        cmd.op = OP_FWALK;
        if (!stat.live || stat.hgt || (stat.heq && !stat.mark)) begin
          st_nxt = ST_BADFREE; state_nxt = S_RES;
        end else if (stat.heq) state_nxt = S_FWH;
      end
      S_FWH: begin cmd.op = OP_WH; state_nxt = S_FWT; end
      S_FWT: begin cmd.op = OP_WT; state_nxt = S_SCAN0; end
      S_SCAN0: begin cmd.op = OP_SCAN0; state_nxt = S_SCAN; end
      S_SCAN: begin
        if (!stat.live) state_nxt = S_EMPTY;
        else if (stat.mark) state_nxt = S_RDNX;
        else cmd.op = OP_SCAN;
      end
      S_EMPTY: begin
        cmd.op = OP_INIT;
        if (stat.init_last) begin
          emp_nxt = 1'b1; state_nxt = S_RES;
        end
      end
      S_RDNX: begin cmd.op = OP_RDNEXT; state_nxt = S_MNX; end
      S_MNX: begin
        cmd.op = OP_MNEXT;
        state_nxt = stat.merge_ok ? S_NWH : S_RDPV;
      end
      S_NWH: begin cmd.op = OP_WH; state_nxt = S_NWT; end
      S_NWT: begin cmd.op = OP_WT; state_nxt = S_RDPV; end
      S_RDPV: begin cmd.op = OP_RDPREV; state_nxt = S_MPV; end
      S_MPV: begin
        cmd.op = OP_MPREV;
        state_nxt = (stat.merge_ok && stat.prev_fits) ? S_PWH : S_RES;
      end
      S_PWH: begin cmd.op = OP_WH; state_nxt = S_PWT; end
      S_PWT: begin cmd.op = OP_WT; state_nxt = S_RES; end
      S_RES: begin cmd.op = OP_RESULT; state_nxt = S_OUT; end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      st_r    <= ST_OK;
      emp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      emp_r   <= emp_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

// ===== hdl/boundary_tag_best_fit_allocator_top.sv =====
// Top level of the boundary-tag best-fit allocator.
// Depends on btbf_pkg, btbf_ctrl and btbf_datapath.

// The allocator keeps one arena of 32-bit words in a single-port-write,
// registered-read memory, with a size tag at the head and tail of every
// block. A request beat is taken when start is high and busy is low; the
// result beat appears on out_item for exactly one cycle with out_valid high
// and cannot be held off, so the receiver must take it then. After reset the
// block writes the sentinel and initial tags and keeps busy high meanwhile.
// An allocate walks the block chain at one memory read per block until it
// reads the closing sentinel or an exact match stops the walk early, then
// writes the head and tail tags of the chosen block, and those of the
// remainder when the chosen block is split; a failed allocate ends after
// its walk and a zero size ends at once. A free walks up to the named block,
// then walks the chain again to see whether anything stays allocated, and
// then merges with its neighbors. A free that empties the arena rewrites
// the initial layout instead, and a bad free ends after its walk. One item
// is in flight at a time.
module boundary_tag_best_fit_allocator_top #(
  parameter int ARENA_BYTES = btbf_pkg::ARENA_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  btbf_pkg::in_t  in_item,
  output logic           out_valid,
  output btbf_pkg::out_t out_item
);
  import btbf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller decides the step; the datapath owns the arena and tags.
  btbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  btbf_datapath #(
    .ARENA_BYTES (ARENA_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

  // A result beat lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held longer than one cycle");

  // An accepted request makes the block busy at the next edge.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");

  // A result is only shown while the block still reports busy.
  a_out_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  // Failed results carry no grant.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |->
      (out_item.granted_offset == '0 && out_item.granted_bytes == '0))
    else $error("failed result carries a grant");

endmodule
